### hdl/mss_pkg.sv
// Shared types, codes and constants of the MIDI step sequencer.
package mss_pkg;

	localparam int MAX_STEPS_DEF = 32;
	localparam int DIVISIONS_DEF = 17;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPW           = $clog2(QUEUE_DEPTH);
	localparam int QCW           = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IW        = 3;
	localparam int CFG_DW        = 7;

	localparam logic [3:0] FN_TICK      = 4'd0;
	localparam logic [3:0] FN_NOTE_ON   = 4'd1;
	localparam logic [3:0] FN_NOTE_OFF  = 4'd2;
	localparam logic [3:0] FN_START     = 4'd3;
	localparam logic [3:0] FN_STOP      = 4'd4;
	localparam logic [3:0] FN_CONTINUE  = 4'd5;
	localparam logic [3:0] FN_RUN_ON    = 4'd6;
	localparam logic [3:0] FN_RUN_OFF   = 4'd7;
	localparam logic [3:0] FN_WR_STEP   = 4'd8;
	localparam logic [3:0] FN_WR_TABLE  = 4'd9;

	localparam logic [1:0] CLK_INTERNAL = 2'd0;
	localparam logic [1:0] CLK_NOTE     = 2'd2;

	localparam logic [1:0] CNT_REALTIME = 2'd1;
	localparam logic [1:0] CNT_CHANNEL  = 2'd3;

	localparam logic [7:0] RT_CLOCK = 8'hF8;
	localparam logic [7:0] RT_START = 8'hFA;
	localparam logic [7:0] RT_STOP  = 8'hFC;

	localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
	localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
	localparam logic [3:0] MSG_CC       = 4'hB;

	localparam logic [6:0] CC_ALL_NOTES_OFF = 7'd123;
	localparam logic [6:0] DEFAULT_ROOT     = 7'd60;
	localparam logic [6:0] DATA_MAX         = 7'd127;

	localparam int TE_NOTE = 0;
	localparam int TE_DUR  = 1;
	localparam int TE_VEL  = 2;
	localparam int TE_CC   = 3;

	localparam logic [1:0] RST_CLOCK_MODE      = 2'd0;
	localparam logic [3:0] RST_MIDI_CHANNEL    = 4'd0;
	localparam logic [6:0] RST_CC_CONTROLLER   = 7'd74;
	localparam logic [3:0] RST_TRACK_ENABLES   = 4'hF;
	localparam logic [4:0] RST_DIVISION_SELECT = 5'd12;
	localparam logic [5:0] RST_STEP_COUNT      = 6'd8;
	localparam logic [6:0] RST_FIXED_VELOCITY  = 7'd100;

	typedef enum logic [2:0] {
		CFG_CLOCK_MODE,
		CFG_MIDI_CHANNEL,
		CFG_CC_CONTROLLER,
		CFG_TRACK_ENABLES,
		CFG_DIVISION_SELECT,
		CFG_STEP_COUNT,
		CFG_FIXED_VELOCITY
	} cfg_index_t;

	typedef struct packed {
		logic [1:0] clock_mode;
		logic [3:0] midi_channel;
		logic [6:0] cc_controller;
		logic [3:0] track_enables;
		logic [4:0] division_select;
		logic [5:0] step_count;
		logic [6:0] fixed_velocity;
	} cfg_t;

	typedef struct packed {
		logic [3:0] func;
		logic [1:0] clock_source;
		logic [3:0] event_channel;
		logic [6:0] event_note;
		logic [6:0] event_velocity;
		logic [4:0] step_index;
		logic [6:0] step_note;
		logic [4:0] step_length;
		logic [3:0] step_level;
		logic [6:0] step_cc_value;
		logic [4:0] table_index;
		logic [7:0] table_ticks;
	} item_fields_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_TICK,
		OP_NOTE_ON,
		OP_NOTE_OFF,
		OP_START,
		OP_STOP,
		OP_CONTINUE,
		OP_RUN_ON,
		OP_RUN_OFF,
		OP_WR_STEP,
		OP_WR_TABLE
	} op_t;

	typedef struct packed {
		op_t          op;
		item_fields_t f;
	} qitem_t;

	typedef struct packed {
		logic [6:0] cc;
		logic [3:0] level;
		logic [4:0] length;
		logic [6:0] note;
	} step_t;

	typedef struct packed {
		logic [1:0] byte_count;
		logic [7:0] status_byte;
		logic [6:0] data_one;
		logic [6:0] data_two;
		logic       schedule_off;
		logic [7:0] off_delay;
		logic       flush_request;
		logic       last;
	} result_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_EVAL,
		BK_DUR,
		BK_DRAIN
	} back_state_t;

endpackage

### hdl/mss_front.sv
// Front part: accepts input requests, classifies them and queues them for the back part.
module mss_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mss_pkg::item_fields_t in_data,
	output logic                 q_valid,
	output mss_pkg::qitem_t      q_item,
	input  logic                 q_pop
);
	import mss_pkg::*;

	qitem_t           qmem [QUEUE_DEPTH];
	logic [QPW-1:0]   wr_ptr_q;
	logic [QPW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;
	op_t              op;
	logic             push;

	function automatic op_t classify(input logic [3:0] fn);
		case (fn)
			FN_TICK:     return OP_TICK;
			FN_NOTE_ON:  return OP_NOTE_ON;
			FN_NOTE_OFF: return OP_NOTE_OFF;
			FN_START:    return OP_START;
			FN_STOP:     return OP_STOP;
			FN_CONTINUE: return OP_CONTINUE;
			FN_RUN_ON:   return OP_RUN_ON;
			FN_RUN_OFF:  return OP_RUN_OFF;
			FN_WR_STEP:  return OP_WR_STEP;
			FN_WR_TABLE: return OP_WR_TABLE;
			default:     return OP_NONE;
		endcase
	endfunction

	assign op       = classify(in_data.func);
	assign in_stall = (count_q == QCW'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall && (op != OP_NONE);
	assign q_valid  = (count_q != '0);
	assign q_item   = qmem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			qmem[wr_ptr_q] <= '{op: op, f: in_data};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPW'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + QPW'(1);
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + QCW'(1);
				2'b01:   count_q <= count_q - QCW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("queue popped while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= QUEUE_DEPTH)
		else $error("queue count beyond depth");

endmodule

### hdl/mss_back.sv
// Back part: sequencer state, pattern and ticks-table memories, result buffer and output register.
module mss_back #(
	parameter int MAX_STEPS = mss_pkg::MAX_STEPS_DEF,
	parameter int DIVISIONS = mss_pkg::DIVISIONS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mss_pkg::cfg_t    cfg,
	input  logic             q_valid,
	input  mss_pkg::qitem_t  q_item,
	output logic             q_pop,
	output logic             out_valid,
	output mss_pkg::result_t out_res,
	input  logic             out_stall
);
	import mss_pkg::*;

	localparam int SW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	localparam int DW = $clog2(DIVISIONS);

	step_t       pat_mem [MAX_STEPS];
	logic [7:0]  tbl_mem [DIVISIONS];

	back_state_t state_q, state_d;
	logic        running_q, running_d;
	logic [7:0]  tick_count_q, tick_d;
	logic [SW-1:0] play_step_q, play_d;
	logic [6:0]  root_q, root_d;
	logic [6:0]  latest_q, latest_d;

	qitem_t      item_s1;
	step_t       pat_rd_s1;
	logic [7:0]  tbl_rd_s1;

	step_t       step_q, step_d;
	logic [7:0]  pre_q, pre_d;
	logic        f8_q, f8_d;

	result_t     res_q [3];
	result_t     res_d [3];
	logic [1:0]  res_n_q, n_d;
	logic [1:0]  res_ptr_q, ptr_d;
	logic        res_we;

	logic        out_valid_q;
	result_t     out_q, out_d;
	logic        out_load;

	logic        tbl_re;
	logic [DW-1:0] tbl_raddr;
	logic        pat_we;
	logic        tbl_we;
	step_t       pat_wdata;

	logic        internal;
	logic        fire;
	logic        do_start, do_stop, set_root, set_latest, fwd_on, fwd_off;
	logic [7:0]  tc1;
	logic [SW:0] nxt;
	logic signed [8:0] pitch;
	logic [6:0]  pitch_clip;
	logic [6:0]  vel;
	logic [7:0]  dur;

	function automatic logic [DW-1:0] tbl_idx(input logic [4:0] i);
		if (int'(i) >= DIVISIONS) begin
			return DW'(DIVISIONS - 1);
		end
		return DW'(i);
	endfunction

	function automatic result_t mk_res(input logic [1:0] cnt, input logic [7:0] st,
		input logic [6:0] d1, input logic [6:0] d2, input logic sch,
		input logic [7:0] dly, input logic fl);
		result_t r;
		r.byte_count    = cnt;
		r.status_byte   = st;
		r.data_one      = d1;
		r.data_two      = d2;
		r.schedule_off  = sch;
		r.off_delay     = dly;
		r.flush_request = fl;
		r.last          = 1'b0;
		return r;
	endfunction

	assign internal  = (cfg.clock_mode == CLK_INTERNAL);
	assign pat_wdata = '{cc: item_s1.f.step_cc_value, level: item_s1.f.step_level,
		length: item_s1.f.step_length, note: item_s1.f.step_note};

	assign tc1 = tick_count_q + 8'd1;
	assign nxt = {1'b0, play_step_q} + (SW + 1)'(1);

	assign pitch = $signed({2'b00, step_q.note}) + $signed({2'b00, latest_q})
		- $signed({2'b00, root_q});
	assign pitch_clip = (pitch < 0) ? 7'd0 : ((pitch > 9'sd127) ? DATA_MAX : pitch[6:0]);
	assign vel = cfg.track_enables[TE_VEL] ? {step_q.level, 3'b000} : cfg.fixed_velocity;
	assign dur = cfg.track_enables[TE_DUR] ? tbl_rd_s1 : pre_q;

	always_comb begin
		state_d    = state_q;
		running_d  = running_q;
		tick_d     = tick_count_q;
		play_d     = play_step_q;
		root_d     = root_q;
		latest_d   = latest_q;
		step_d     = step_q;
		pre_d      = pre_q;
		f8_d       = f8_q;
		for (int i = 0; i < 3; i++) begin
			res_d[i] = res_q[i];
		end
		n_d        = 2'd0;
		res_we     = 1'b0;
		ptr_d      = res_ptr_q;
		q_pop      = 1'b0;
		tbl_re     = 1'b0;
		tbl_raddr  = tbl_idx(cfg.division_select);
		pat_we     = 1'b0;
		tbl_we     = 1'b0;
		out_load   = 1'b0;
		out_d      = res_q[res_ptr_q];
		out_d.last = (res_ptr_q == res_n_q - 2'd1);
		fire       = 1'b0;
		do_start   = 1'b0;
		do_stop    = 1'b0;
		set_root   = 1'b0;
		set_latest = 1'b0;
		fwd_on     = 1'b0;
		fwd_off    = 1'b0;

		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					tbl_re  = 1'b1;
					state_d = BK_EVAL;
				end
			end
			BK_EVAL: begin
				res_we = 1'b1;
				ptr_d  = 2'd0;
				case (item_s1.op)
					OP_TICK: begin
						if (cfg.clock_mode == item_s1.f.clock_source && running_q) begin
							if (tc1 < tbl_rd_s1) begin
								tick_d = tc1;
								if (item_s1.f.clock_source == CLK_INTERNAL) begin
									res_d[n_d] = mk_res(CNT_REALTIME, RT_CLOCK, 7'd0, 7'd0,
										1'b0, 8'd0, 1'b0);
									n_d = n_d + 2'd1;
								end
							end else begin
								fire      = 1'b1;
								tick_d    = 8'd0;
								step_d    = pat_rd_s1;
								pre_d     = tbl_rd_s1;
								f8_d      = (item_s1.f.clock_source == CLK_INTERNAL);
								tbl_re    = 1'b1;
								tbl_raddr = tbl_idx(pat_rd_s1.length);
								if (int'(nxt) >= int'(cfg.step_count) || int'(nxt) >= MAX_STEPS)
								begin
									play_d = '0;
								end else begin
									play_d = nxt[SW-1:0];
								end
							end
						end
					end
					OP_NOTE_ON: begin
						if (cfg.clock_mode != CLK_NOTE
							&& item_s1.f.event_channel == cfg.midi_channel) begin
							fwd_on = !cfg.track_enables[TE_NOTE];
							if (internal) begin
								if (running_q && item_s1.f.event_note == latest_q
									&& cfg.track_enables[TE_NOTE]) begin
									do_stop = 1'b1;
								end else if (!running_q) begin
									do_start = 1'b1;
									set_root = 1'b1;
								end
							end
							set_latest = 1'b1;
						end
					end
					OP_NOTE_OFF: begin
						if (cfg.clock_mode != CLK_NOTE
							&& item_s1.f.event_channel == cfg.midi_channel) begin
							fwd_off = !cfg.track_enables[TE_NOTE] || !running_q;
						end
					end
					OP_START:    do_start = !internal;
					OP_STOP:     do_stop  = !internal;
					OP_CONTINUE: begin
						if (!internal) begin
							running_d = 1'b1;
						end
					end
					OP_RUN_ON:   do_start = 1'b1;
					OP_RUN_OFF:  do_stop  = 1'b1;
					OP_WR_STEP:  pat_we = (int'(item_s1.f.step_index) < MAX_STEPS);
					OP_WR_TABLE: tbl_we = (int'(item_s1.f.table_index) < DIVISIONS);
					default: ;
				endcase

				do_start = do_start && !running_q;
				do_stop  = do_stop && running_q;

				if (fwd_on) begin
					res_d[n_d] = mk_res(CNT_CHANNEL, {MSG_NOTE_ON, item_s1.f.event_channel},
						item_s1.f.event_note, item_s1.f.event_velocity, 1'b0, 8'd0, 1'b0);
					n_d = n_d + 2'd1;
				end
				if (fwd_off) begin
					res_d[n_d] = mk_res(CNT_CHANNEL, {MSG_NOTE_OFF, item_s1.f.event_channel},
						item_s1.f.event_note, item_s1.f.event_velocity, 1'b0, 8'd0, 1'b0);
					n_d = n_d + 2'd1;
				end
				if (do_start) begin
					if (internal) begin
						res_d[n_d] = mk_res(CNT_REALTIME, RT_START, 7'd0, 7'd0,
							1'b0, 8'd0, 1'b0);
						n_d = n_d + 2'd1;
					end
					if (root_q == 7'd0 || latest_q == 7'd0) begin
						root_d   = DEFAULT_ROOT;
						latest_d = DEFAULT_ROOT;
					end
					tick_d    = tbl_rd_s1 - 8'd1;
					play_d    = '0;
					running_d = 1'b1;
				end
				if (do_stop) begin
					res_d[n_d] = mk_res(CNT_CHANNEL, {MSG_CC, cfg.midi_channel},
						CC_ALL_NOTES_OFF, 7'd0, 1'b0, 8'd0, 1'b1);
					n_d = n_d + 2'd1;
					if (internal) begin
						res_d[n_d] = mk_res(CNT_REALTIME, RT_STOP, 7'd0, 7'd0,
							1'b0, 8'd0, 1'b0);
						n_d = n_d + 2'd1;
					end
					running_d = 1'b0;
					root_d    = 7'd0;
					latest_d  = 7'd0;
				end
				if (set_root) begin
					root_d = item_s1.f.event_note;
				end
				if (set_latest) begin
					latest_d = item_s1.f.event_note;
				end

				if (fire) begin
					state_d = BK_DUR;
				end else if (n_d != 2'd0) begin
					state_d = BK_DRAIN;
				end else begin
					state_d = BK_IDLE;
				end
			end
			BK_DUR: begin
				res_we = 1'b1;
				ptr_d  = 2'd0;
				if (f8_q) begin
					res_d[n_d] = mk_res(CNT_REALTIME, RT_CLOCK, 7'd0, 7'd0, 1'b0, 8'd0, 1'b0);
					n_d = n_d + 2'd1;
				end
				if (cfg.track_enables[TE_CC]) begin
					res_d[n_d] = mk_res(CNT_CHANNEL, {MSG_CC, cfg.midi_channel},
						cfg.cc_controller, step_q.cc, 1'b0, 8'd0, 1'b0);
					n_d = n_d + 2'd1;
				end
				if (cfg.track_enables[TE_NOTE] && vel != 7'd0) begin
					res_d[n_d] = mk_res(CNT_CHANNEL, {MSG_NOTE_ON, cfg.midi_channel},
						pitch_clip, vel, 1'b1, dur - 8'd1, 1'b0);
					n_d = n_d + 2'd1;
				end
				state_d = (n_d != 2'd0) ? BK_DRAIN : BK_IDLE;
			end
			BK_DRAIN: begin
				out_load = !out_valid_q || !out_stall;
				if (out_load) begin
					ptr_d = res_ptr_q + 2'd1;
					if (res_ptr_q == res_n_q - 2'd1) begin
						if (q_valid) begin
							q_pop   = 1'b1;
							tbl_re  = 1'b1;
							state_d = BK_EVAL;
						end else begin
							state_d = BK_IDLE;
						end
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_mem[SW'(item_s1.f.step_index)] <= pat_wdata;
		end
		if (q_pop) begin
			pat_rd_s1 <= pat_mem[play_step_q];
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[DW'(item_s1.f.table_index)] <= item_s1.f.table_ticks;
		end
		if (tbl_re) begin
			tbl_rd_s1 <= tbl_mem[tbl_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1 <= q_item;
		end
		step_q <= step_d;
		pre_q  <= pre_d;
		f8_q   <= f8_d;
		if (res_we) begin
			for (int i = 0; i < 3; i++) begin
				res_q[i] <= res_d[i];
			end
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			running_q    <= 1'b0;
			tick_count_q <= 8'd0;
			play_step_q  <= '0;
			root_q       <= 7'd0;
			latest_q     <= 7'd0;
			res_n_q      <= 2'd0;
			res_ptr_q    <= 2'd0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			running_q    <= running_d;
			tick_count_q <= tick_d;
			play_step_q  <= play_d;
			root_q       <= root_d;
			latest_q     <= latest_d;
			res_ptr_q    <= ptr_d;
			if (res_we) begin
				res_n_q <= n_d;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	a_drain_has_results: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DRAIN) |-> (res_n_q != 2'd0))
		else $error("draining an empty result buffer");
	a_drain_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DRAIN) |-> (res_ptr_q < res_n_q))
		else $error("result pointer past result count");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(play_step_q) < MAX_STEPS)
		else $error("step pointer beyond pattern length");

endmodule

### hdl/midi_step_sequencer.sv
// Top level of the MIDI step sequencer: configuration registers and the front and back parts.
//
// The block takes clock ticks, note and transport requests and returns MIDI messages one per
// output request, each group closed by last. Input requests go into a four-entry queue, so a
// burst of up to four is taken at one per cycle while results are still being delivered. The
// back part then pops a request together with its memory reads and evaluates it; a tick that
// plays a step also passes through a second ticks-table read before its messages are built.
// Messages are delivered one at a time, each held while out_stall is high, with the next
// request's memory reads overlapping the last message; the single read ports of the pattern
// memory and the ticks table with their registered outputs set this pace.
// Both memories hold unknown contents until written and have no clearing pass. Configuration
// writes are taken in every cycle (cfg_ready stays high) and belong in periods of no traffic.
module midi_step_sequencer #(
	parameter int MAX_STEPS = mss_pkg::MAX_STEPS_DEF,
	parameter int DIVISIONS = mss_pkg::DIVISIONS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [6:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [3:0] func,
	input  logic [1:0] clock_source,
	input  logic [3:0] event_channel,
	input  logic [6:0] event_note,
	input  logic [6:0] event_velocity,
	input  logic [4:0] step_index,
	input  logic [6:0] step_note,
	input  logic [4:0] step_length,
	input  logic [3:0] step_level,
	input  logic [6:0] step_cc_value,
	input  logic [4:0] table_index,
	input  logic [7:0] table_ticks,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] byte_count,
	output logic [7:0] status_byte,
	output logic [6:0] data_one,
	output logic [6:0] data_two,
	output logic       schedule_off,
	output logic [7:0] off_delay,
	output logic       flush_request,
	output logic       last
);
	import mss_pkg::*;

	cfg_t         cfg_q;
	item_fields_t in_data;
	qitem_t       q_item;
	logic         q_valid;
	logic         q_pop;
	result_t      out_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clock_mode      <= RST_CLOCK_MODE;
			cfg_q.midi_channel    <= RST_MIDI_CHANNEL;
			cfg_q.cc_controller   <= RST_CC_CONTROLLER;
			cfg_q.track_enables   <= RST_TRACK_ENABLES;
			cfg_q.division_select <= RST_DIVISION_SELECT;
			cfg_q.step_count      <= RST_STEP_COUNT;
			cfg_q.fixed_velocity  <= RST_FIXED_VELOCITY;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CLOCK_MODE:      cfg_q.clock_mode      <= cfg_data[1:0];
				CFG_MIDI_CHANNEL:    cfg_q.midi_channel    <= cfg_data[3:0];
				CFG_CC_CONTROLLER:   cfg_q.cc_controller   <= cfg_data;
				CFG_TRACK_ENABLES:   cfg_q.track_enables   <= cfg_data[3:0];
				CFG_DIVISION_SELECT: cfg_q.division_select <= cfg_data[4:0];
				CFG_STEP_COUNT:      cfg_q.step_count      <= cfg_data[5:0];
				CFG_FIXED_VELOCITY:  cfg_q.fixed_velocity  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_data.func           = func;
	assign in_data.clock_source   = clock_source;
	assign in_data.event_channel  = event_channel;
	assign in_data.event_note     = event_note;
	assign in_data.event_velocity = event_velocity;
	assign in_data.step_index     = step_index;
	assign in_data.step_note      = step_note;
	assign in_data.step_length    = step_length;
	assign in_data.step_level     = step_level;
	assign in_data.step_cc_value  = step_cc_value;
	assign in_data.table_index    = table_index;
	assign in_data.table_ticks    = table_ticks;

	mss_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	mss_back #(
		.MAX_STEPS (MAX_STEPS),
		.DIVISIONS (DIVISIONS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_res   (out_res),
		.out_stall (out_stall)
	);

	assign byte_count    = out_res.byte_count;
	assign status_byte   = out_res.status_byte;
	assign data_one      = out_res.data_one;
	assign data_two      = out_res.data_two;
	assign schedule_off  = out_res.schedule_off;
	assign off_delay     = out_res.off_delay;
	assign flush_request = out_res.flush_request;
	assign last          = out_res.last;

endmodule
